// ===== hdl/bdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdpc_pkg
// Types and constants shared by the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int BDPC_BUTTONS = 16;

  localparam int ID_W       = 4;
  localparam int TIME_W     = 32;
  localparam int DEB_W      = 10;
  localparam int LONG_W     = 13;
  localparam int MASK_W     = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [LONG_W-1:0] LONG_MIN_MS = 13'd100;
  localparam logic [LONG_W-1:0] LONG_MAX_MS = 13'd5000;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 10'd20;
  localparam logic [LONG_W-1:0] LONG_RESET     = 13'd600;
  localparam logic [MASK_W-1:0] MASK_RESET     = 16'hFFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMIT_DOWN_UP    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW_MASK = 4'd3;

  typedef enum logic [1:0] {
    KIND_DOWN  = 2'd0,
    KIND_UP    = 2'd1,
    KIND_SHORT = 2'd2,
    KIND_LONG  = 2'd3
  } ev_kind_t;

  typedef struct packed {
    logic [ID_W-1:0] button;
    ev_kind_t        kind;
    logic            last;
  } event_t;

  // per-button state record
  typedef struct packed {
    logic              raw_rel;
    logic              stab_rel;
    logic [TIME_W-1:0] change_time;
    logic [TIME_W-1:0] press_time;
    logic              long_rep;
  } btn_rec_t;

  localparam btn_rec_t REC_RESET = '{
    raw_rel:     1'b1,
    stab_rel:    1'b1,
    change_time: '0,
    press_time:  '0,
    long_rep:    1'b0
  };

endpackage

// ===== hdl/bdpc_rec_mem.sv =====
// ----------------------------------------------------------------------------
// bdpc_rec_mem
// Per-button state memory: one write port, one registered read port, with a
// valid bit per entry so that untouched buttons read as the reset record.
// ----------------------------------------------------------------------------
module bdpc_rec_mem #(
  parameter int BUTTONS = bdpc_pkg::BDPC_BUTTONS,
  parameter int AW      = (BUTTONS > 1) ? $clog2(BUTTONS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output bdpc_pkg::btn_rec_t rd_rec,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  bdpc_pkg::btn_rec_t wr_rec
);
  import bdpc_pkg::*;

  btn_rec_t           mem [BUTTONS];
  btn_rec_t           rd_q;
  logic [BUTTONS-1:0] vld;
  logic               rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_rec = rd_vld ? rd_q : REC_RESET;

endmodule

// ===== hdl/button_debounce_press_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_unit
// Debounces pin samples per button and reports down, up, short and long press.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one pin sample per transaction:
//   button_id, level_high and the millisecond timestamp now_ms.
//   Output channel (out_valid/out_ready) gives zero, one or two events per
//   sample; last marks the final event of a sample.
//   Config channel (cfg_valid/cfg_ready) writes debounce_ms, long_press_ms,
//   emit_down_up and active_low_mask; cfg_ready is always high. Write only
//   while no sample is in flight.
//   Pipeline: a sample is registered in the compute stage, its events in the
//   output stage. Throughput: one sample per cycle while the output stage has
//   room. The rate is set by the two-port state memory read at acceptance and
//   written back from the compute stage, with the write forwarded to a
//   following sample of the same button.
//   Reset: every button reads as released with zero times (per-entry valid
//   bits, no clearing pass); registers return to their default values.
//   Stall: a two-event output stage holds results; while it holds events not
//   yet taken, a sample with events holds the compute stage and in_ready drops.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_unit #(
  parameter int BUTTONS = bdpc_pkg::BDPC_BUTTONS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bdpc_pkg::ID_W-1:0]         button_id,
  input  logic                              level_high,
  input  logic [bdpc_pkg::TIME_W-1:0]       now_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bdpc_pkg::ID_W-1:0]         event_button,
  output logic [1:0]                        event_kind,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bdpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bdpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bdpc_pkg::*;

  localparam int AW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  // configuration registers
  logic [DEB_W-1:0]  debounce_ms;
  logic [LONG_W-1:0] long_press_ms;
  logic              emit_down_up;
  logic [MASK_W-1:0] active_low_mask;

  // compute stage
  logic              s1_valid;
  logic              s1_ok;
  logic [ID_W-1:0]   s1_id;
  logic              s1_level;
  logic [TIME_W-1:0] s1_now;
  logic              s1_fire;

  logic              in_fire;
  logic              fwd;
  btn_rec_t          hold;
  btn_rec_t          rd_rec;
  btn_rec_t          cur;
  btn_rec_t          nx;
  logic              wr_en;

  logic              rel;
  logic [TIME_W-1:0] chg_t;
  logic              settled;
  logic              long_hit;
  event_t            ev0;
  event_t            ev1;
  logic [1:0]        ev_n;

  // output stage
  logic [1:0]        o_cnt;
  event_t            o_ev0;
  event_t            o_ev1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms     <= DEBOUNCE_RESET;
      long_press_ms   <= LONG_RESET;
      emit_down_up    <= 1'b0;
      active_low_mask <= MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE_MS: begin
          debounce_ms <= cfg_data[DEB_W-1:0];
        end
        REG_LONG_PRESS_MS: begin
          if (cfg_data[LONG_W-1:0] inside {[LONG_MIN_MS:LONG_MAX_MS]}) begin
            long_press_ms <= cfg_data[LONG_W-1:0];
          end
        end
        REG_EMIT_DOWN_UP: begin
          emit_down_up <= cfg_data[0];
        end
        REG_ACTIVE_LOW_MASK: begin
          active_low_mask <= cfg_data[MASK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
    if (in_fire) begin
      s1_ok    <= (int'(button_id) < BUTTONS);
      s1_id    <= button_id;
      s1_level <= level_high;
      s1_now   <= now_ms;
    end
  end

  bdpc_rec_mem #(
    .BUTTONS (BUTTONS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_addr (AW'(button_id)),
    .rd_rec  (rd_rec),
    .wr_en   (wr_en),
    .wr_addr (AW'(s1_id)),
    .wr_rec  (nx)
  );

  // forward the write-back of the previous sample, or keep the record
  // while the stage is held
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (in_fire) begin
      fwd <= wr_en && (s1_id == button_id);
    end else if (s1_valid && !s1_fire) begin
      fwd <= 1'b1;
    end else begin
      fwd <= 1'b0;
    end
    if (in_fire) begin
      hold <= nx;
    end else if (s1_valid && !s1_fire) begin
      hold <= cur;
    end
  end

  assign cur      = fwd ? hold : rd_rec;
  assign rel      = active_low_mask[s1_id] ? s1_level : !s1_level;
  assign chg_t    = (rel != cur.raw_rel) ? s1_now : cur.change_time;
  assign settled  = (s1_now - chg_t) >= TIME_W'(debounce_ms);
  assign long_hit = (s1_now - cur.press_time) >= TIME_W'(long_press_ms);

  always_comb begin
    nx             = cur;
    nx.raw_rel     = rel;
    nx.change_time = chg_t;
    ev0            = '{button: s1_id, kind: KIND_DOWN, last: 1'b1};
    ev1            = '{button: s1_id, kind: KIND_SHORT, last: 1'b1};
    ev_n           = 2'd0;
    if (settled) begin
      if (rel != cur.stab_rel) begin
        nx.stab_rel = rel;
        if (!rel) begin
          nx.press_time = s1_now;
          nx.long_rep   = 1'b0;
          if (emit_down_up) begin
            ev_n = 2'd1;
          end
        end else if (emit_down_up) begin
          ev0.kind = KIND_UP;
          if (!cur.long_rep) begin
            ev0.last = 1'b0;
            ev_n     = 2'd2;
          end else begin
            ev_n = 2'd1;
          end
        end else if (!cur.long_rep) begin
          ev0.kind = KIND_SHORT;
          ev_n     = 2'd1;
        end
      end else if (!cur.stab_rel && !cur.long_rep && long_hit) begin
        nx.long_rep = 1'b1;
        ev0.kind    = KIND_LONG;
        ev_n        = 2'd1;
      end
    end
    if (!s1_ok) begin
      ev_n = 2'd0;
    end
  end

  assign s1_fire = s1_valid &&
                   (ev_n == 2'd0 || o_cnt == 2'd0 || (o_cnt == 2'd1 && out_ready));
  assign wr_en   = s1_fire && s1_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_cnt <= 2'd0;
    end else if (s1_fire && ev_n != 2'd0) begin
      o_cnt <= ev_n;
      o_ev0 <= ev0;
      o_ev1 <= ev1;
    end else if (out_valid && out_ready) begin
      o_cnt <= o_cnt - 2'd1;
      o_ev0 <= o_ev1;
    end
  end

  assign out_valid    = (o_cnt != 2'd0);
  assign event_button = o_ev0.button;
  assign event_kind   = o_ev0.kind;
  assign last         = o_ev0.last;

  // output stage never holds more than one sample's events
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    o_cnt != 2'd3)
    else $error("output stage count out of range");

  // new events only load when the output stage has room for them
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && ev_n != 2'd0) |->
      (o_cnt == 2'd0 || (o_cnt == 2'd1 && out_ready)))
    else $error("events loaded over pending results");

  // forwarded record only ever serves a sample held in the compute stage
  a_fwd_stage: assert property (@(posedge clk) disable iff (rst)
    fwd |-> s1_valid)
    else $error("forwarding active with empty compute stage");

  // a held stage keeps its sample
  a_hold_sample: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |=> (s1_valid && $stable(s1_id) && $stable(s1_now)))
    else $error("compute stage lost a held sample");

endmodule

// ===== tb/button_debounce_press_classifier_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_unit_tb
// Drives pin samples and register writes into the debounce and press
// classifier. It predicts the down, up, short and long events of every
// accepted sample and checks each output transaction against them in order.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_unit_tb;
  import bdpc_pkg::*;

  // per-button debounce and press tracker, plus the queue of events still due
  class press_event_board;
    bit [DEB_W-1:0]    debounce;
    bit [LONG_W-1:0]   long_hold;
    bit                emit;
    bit [MASK_W-1:0]   low_mask;
    bit                raw_rel   [BDPC_BUTTONS];
    bit                stab_rel  [BDPC_BUTTONS];
    bit [TIME_W-1:0]   change_at [BDPC_BUTTONS];
    bit [TIME_W-1:0]   press_at  [BDPC_BUTTONS];
    bit                long_done [BDPC_BUTTONS];
    event_t            pending[$];
    int                errors;

    function new();
      debounce  = DEBOUNCE_RESET;
      long_hold = LONG_RESET;
      emit      = 1'b0;
      low_mask  = MASK_RESET;
      errors    = 0;
      for (int i = 0; i < BDPC_BUTTONS; i++) begin
        raw_rel[i]   = 1'b1;
        stab_rel[i]  = 1'b1;
        change_at[i] = '0;
        press_at[i]  = '0;
        long_done[i] = 1'b0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DEBOUNCE_MS: debounce = data[DEB_W-1:0];
        REG_LONG_PRESS_MS: begin
          // out-of-range hold times leave the register alone
          if (data[LONG_W-1:0] >= LONG_MIN_MS && data[LONG_W-1:0] <= LONG_MAX_MS)
            long_hold = data[LONG_W-1:0];
        end
        REG_EMIT_DOWN_UP: emit = data[0];
        REG_ACTIVE_LOW_MASK: low_mask = data[MASK_W-1:0];
        default: ;
      endcase
    endfunction

    function event_t tag_event(logic [ID_W-1:0] id, ev_kind_t kind);
      event_t ev;
      ev.button = id;
      ev.kind   = kind;
      ev.last   = 1'b0;
      return ev;
    endfunction

    function void note_sample(logic [ID_W-1:0] id, logic level, logic [TIME_W-1:0] now);
      event_t fresh[$];
      logic   rel;
      rel = low_mask[id] ? level : ~level;
      if (rel != raw_rel[id]) begin
        raw_rel[id]   = rel;
        change_at[id] = now;
      end
      if (now - change_at[id] < debounce)
        return;
      if (rel != stab_rel[id]) begin
        stab_rel[id] = rel;
        if (!rel) begin
          press_at[id]  = now;
          long_done[id] = 1'b0;
          if (emit)
            fresh.push_back(tag_event(id, KIND_DOWN));
        end else begin
          if (emit)
            fresh.push_back(tag_event(id, KIND_UP));
          if (!long_done[id])
            fresh.push_back(tag_event(id, KIND_SHORT));
        end
      end else if (!stab_rel[id] && !long_done[id] && (now - press_at[id]) >= long_hold) begin
        long_done[id] = 1'b1;
        fresh.push_back(tag_event(id, KIND_LONG));
      end
      if (fresh.size() > 0)
        fresh[fresh.size()-1].last = 1'b1;
      foreach (fresh[i])
        pending.push_back(fresh[i]);
    endfunction

    function void check_event(logic [ID_W-1:0] button, logic [1:0] kind, logic fin);
      event_t exp_ev;
      if (pending.size() == 0) begin
        $display("%0t: unexpected event button %0d kind %0d last %0d", $time, button, kind,
                 fin);
        errors++;
        return;
      end
      exp_ev = pending.pop_front();
      if (exp_ev.button !== button || exp_ev.kind !== kind || exp_ev.last !== fin) begin
        $display("%0t: mismatch, expected button/kind/last %0d/%0d/%0d, got %0d/%0d/%0d",
                 $time, exp_ev.button, exp_ev.kind, exp_ev.last, button, kind, fin);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [ID_W-1:0]       button_id  = '0;
  logic                  level_high = 1'b0;
  logic [TIME_W-1:0]     now_ms     = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic [ID_W-1:0]       event_button;
  logic [1:0]            event_kind;
  logic                  last;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int gap_pct   = 21;
  int stall_pct = 53;

  bit [TIME_W-1:0] btn_clock   [BDPC_BUTTONS];
  bit              btn_pressed [BDPC_BUTTONS];

  press_event_board board = new();

  button_debounce_press_classifier_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .button_id    (button_id),
    .level_high   (level_high),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_button (event_button),
    .event_kind   (event_kind),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        board.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)
        board.note_sample(button_id, level_high, now_ms);
      if (out_valid && out_ready)
        board.check_event(event_button, event_kind, last);
    end
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_sample(input logic [ID_W-1:0] b, input logic lv,
                             input logic [TIME_W-1:0] stamp);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    button_id  <= b;
    level_high <= lv;
    now_ms     <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // leaves cfg_valid high so writes can go back to back
  task automatic send_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // hold off input until every due event is out, then let silent samples finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [TIME_W-1:0] step_ms();
    int unsigned d;
    int unsigned lh;
    int unsigned r;
    d  = board.debounce;
    lh = board.long_hold;
    r  = $urandom_range(0, 99);
    if (r < 8)
      return '0;
    if (r < 30)
      return $urandom_range(0, d);
    // land right around the settle time
    if (r < 45)
      return (d == 0) ? $urandom_range(0, 1) : d - 1 + $urandom_range(0, 2);
    // land right around the long press threshold
    if (r < 60)
      return lh - 1 + $urandom_range(0, 2);
    if (r < 97)
      return $urandom_range(0, 2 * d + lh);
    return $urandom();
  endfunction

  task automatic run_phase(input logic [DEB_W-1:0] deb, input logic [LONG_W-1:0] lh,
                           input logic emit, input logic [MASK_W-1:0] mask,
                           input int gap, input int stall, input int count);
    logic [ID_W-1:0]   hot [3];
    logic [ID_W-1:0]   b;
    logic              lv;
    logic [CFG_IDX_W-1:0] spare_idx;
    drain();
    spare_idx = CFG_IDX_W'($urandom_range(REG_ACTIVE_LOW_MASK + 1, {CFG_IDX_W{1'b1}}));
    if ($urandom_range(0, 1))
      send_reg(REG_LONG_PRESS_MS, CFG_DATA_W'($urandom_range(0, LONG_MIN_MS - 1)));
    else
      send_reg(REG_LONG_PRESS_MS, CFG_DATA_W'($urandom_range(LONG_MAX_MS + 1, 16'hFFFF)));
    send_reg(REG_DEBOUNCE_MS, CFG_DATA_W'(deb));
    send_reg(REG_LONG_PRESS_MS, CFG_DATA_W'(lh));
    send_reg(REG_EMIT_DOWN_UP, CFG_DATA_W'(emit));
    send_reg(REG_ACTIVE_LOW_MASK, mask);
    send_reg(spare_idx, CFG_DATA_W'($urandom()));
    cfg_valid <= 1'b0;
    gap_pct   = gap;
    stall_pct = stall;
    foreach (hot[k])
      hot[k] = ID_W'($urandom_range(0, BDPC_BUTTONS - 1));
    // some clocks start just short of the 32-bit wrap
    foreach (btn_clock[k])
      btn_clock[k] = $urandom_range(0, 1) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(0, 3000);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2)
        drain();
      b = ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 2)]
                                     : ID_W'($urandom_range(0, BDPC_BUTTONS - 1));
      if ($urandom_range(0, 99) < 30)
        btn_pressed[b] = !btn_pressed[b];
      // pressed reads low on active-low buttons
      lv = btn_pressed[b] ? !board.low_mask[b] : board.low_mask[b];
      if ($urandom_range(0, 99) < 20)
        lv = !lv;  // contact bounce
      btn_clock[b] += step_ms();
      send_sample(b, lv, btn_clock[b]);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, advisory events on
    send_reg(REG_EMIT_DOWN_UP, 16'd1);
    cfg_valid <= 1'b0;
    send_sample(4'd0, 1'b0, 32'd0);
    send_sample(4'd0, 1'b0, 32'd20);
    send_sample(4'd0, 1'b0, 32'd619);
    send_sample(4'd0, 1'b0, 32'd620);
    send_sample(4'd0, 1'b1, 32'd710);
    send_sample(4'd0, 1'b1, 32'd730);
    // bounce across the timestamp wrap, then a short press
    send_sample(4'd15, 1'b0, 32'hFFFF_FFF0);
    send_sample(4'd15, 1'b1, 32'hFFFF_FFF8);
    send_sample(4'd15, 1'b0, 32'hFFFF_FFFA);
    send_sample(4'd15, 1'b0, 32'h0000_000E);
    send_sample(4'd15, 1'b1, 32'd256);
    send_sample(4'd15, 1'b1, 32'd276);

    // zero settle time, active-high pins, bad hold times and unused indexes
    drain();
    send_reg(REG_DEBOUNCE_MS, 16'd0);
    send_reg(REG_EMIT_DOWN_UP, 16'd0);
    send_reg(REG_LONG_PRESS_MS, 16'd99);
    send_reg(REG_LONG_PRESS_MS, 16'd5001);
    send_reg(REG_ACTIVE_LOW_MASK, 16'h0000);
    send_reg(CFG_IDX_W'(REG_ACTIVE_LOW_MASK + 1), 16'hFFFF);
    send_reg({CFG_IDX_W{1'b1}}, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_sample(4'd7, 1'b1, 32'hFFFF_FFFF);
    send_sample(4'd7, 1'b1, 32'h0000_0257);
    send_sample(4'd7, 1'b0, 32'h0000_0300);
    send_sample(4'd3, 1'b1, 32'd5);
    send_sample(4'd3, 1'b0, 32'd6);

    // largest settle time that fits the register, longest hold
    drain();
    send_reg(REG_DEBOUNCE_MS, 16'h03FF);
    send_reg(REG_LONG_PRESS_MS, 16'd5000);
    send_reg(REG_EMIT_DOWN_UP, 16'd1);
    send_reg(REG_ACTIVE_LOW_MASK, 16'hA5A5);
    cfg_valid <= 1'b0;
    send_sample(4'd2, 1'b0, 32'd0);
    send_sample(4'd2, 1'b0, 32'd1022);
    send_sample(4'd2, 1'b0, 32'd1023);
    send_sample(4'd2, 1'b0, 32'd6022);
    send_sample(4'd2, 1'b0, 32'd6023);
    send_sample(4'd2, 1'b1, 32'd7000);
    send_sample(4'd2, 1'b1, 32'd8023);

    run_phase(10'd20, 13'd600, 1'b1, 16'hFFFF, 21, 53, 180);
    run_phase(10'd0, 13'd100, 1'b1, 16'h0000, 21, 53, 180);
    run_phase(10'd1023, 13'd5000, 1'b0, 16'h5A5A, 53, 21, 180);
    run_phase(10'd5, 13'd150, 1'b1, MASK_W'($urandom()), 53, 21, 180);
    run_phase(10'd1000, 13'd4999, 1'b1, MASK_W'($urandom()), 0, 0, 180);
    run_phase(DEB_W'($urandom_range(0, 60)), LONG_W'($urandom_range(100, 1000)),
              1'($urandom_range(0, 1)), MASK_W'($urandom()), 0, 0, 180);

    in_valid <= 1'b0;
    for (int w = 0; w < 20000 && board.pending.size() != 0; w++)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.pending.size() != 0) begin
      $display("%0t: %0d expected events never arrived", $time, board.pending.size());
      board.errors += board.pending.size();
    end
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
